### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hw/rtl/pgpg_pkg.sv
package pgpg_pkg;

   localparam int PGPG_PALETTE_SIZE = 236;
   localparam int PGPG_IMAGE_WIDTH  = 320;
   localparam int PGPG_IMAGE_HEIGHT = 240;

   localparam int X_W        = 9;
   localparam int Y_W        = 8;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 3 * CHAN_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_RED   = 3'd0,
      REG_START_GREEN = 3'd1,
      REG_START_BLUE  = 3'd2,
      REG_END_RED     = 3'd3,
      REG_END_GREEN   = 3'd4,
      REG_END_BLUE    = 3'd5,
      REG_DIRECTION   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_VERTICAL   = 2'd0,
      DIR_DIAGONAL   = 2'd1,
      DIR_HORIZONTAL = 2'd2,
      DIR_MIRRORED   = 2'd3
   } direction_type;

   localparam logic [CHAN_W-1:0] START_RESET = 8'd0;
   localparam logic [CHAN_W-1:0] END_RESET   = 8'd255;
   localparam direction_type     DIR_RESET   = DIR_DIAGONAL;

endpackage

### hw/rtl/palette_gradient_pixel_generator.sv
// Channel   Ports                                    Transaction
// -------   --------------------------------------   -----------------------------
// request   start, busy, req_pixel_x, req_pixel_y    start high while busy is low
// result    rsp_strobe, rsp_pixel_color              rsp_strobe high for one cycle
// config    csr_we, csr_index, csr_wdata             csr_we high, no wait
//
// One transaction enters every clock; busy is always low.
// The result reaches the result ports through six register stages (numerators, reciprocal
// multiplies, index, channel numerators, channel multiplies, color).
// Reset clears the stage valid bits and loads the default colors and direction.
// The receiver cannot stall, so results leave the pipeline as they complete.
`include "assert_macros.svh"

module palette_gradient_pixel_generator
   import pgpg_pkg::*;
#(
   parameter int PALETTE_SIZE = PGPG_PALETTE_SIZE,
   parameter int IMAGE_WIDTH  = PGPG_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = PGPG_IMAGE_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [X_W-1:0]        req_pixel_x,
   input  logic [Y_W-1:0]        req_pixel_y,
   output logic                  rsp_strobe,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HALF  = PALETTE_SIZE / 2;
   localparam int IDX_W = $clog2(PALETTE_SIZE);
   localparam int LAT   = 6;

   localparam int NY_W = $clog2(2 * PALETTE_SIZE * (2 ** Y_W - 1) + IMAGE_HEIGHT + 1);
   localparam int DY   = 2 * IMAGE_HEIGHT;
   localparam int SY   = NY_W + $clog2(DY);
   localparam longint unsigned MY = ((64'd1 << SY) + DY - 1) / DY;
   localparam int PY_W = SY + NY_W;

   localparam int NX_W = $clog2(2 * PALETTE_SIZE * (2 ** X_W - 1) + IMAGE_WIDTH + 1);
   localparam int DX   = 2 * IMAGE_WIDTH;
   localparam int SX   = NX_W + $clog2(DX);
   localparam longint unsigned MX = ((64'd1 << SX) + DX - 1) / DX;
   localparam int PX_W = SX + NX_W;

   localparam int CB_W = ((NX_W > NY_W) ? NX_W : NY_W) + 2;

   localparam int NC_W = $clog2(511 * (PALETTE_SIZE - 1) + 1);
   localparam int DC   = 2 * (PALETTE_SIZE - 1);
   localparam int SC   = NC_W + $clog2(DC);
   localparam longint unsigned MC = ((64'd1 << SC) + DC - 1) / DC;
   localparam int PC_W = 2 * NC_W + 2;

   logic [CHAN_W-1:0] start_ff [3];
   logic [CHAN_W-1:0] end_ff [3];
   direction_type     dir_ff;

   logic              accept;

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_strobe_ff;
   logic [NY_W-1:0]   ynum_ff, ynum_in;
   logic [NX_W-1:0]   xnum_ff, xnum_in;
   logic [PY_W-1:0]   yprod_ff;
   logic [PX_W-1:0]   xprod_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CB_W-1:0]   sum;
   logic [NC_W-1:0]   cnum_ff [3];
   logic [NC_W-1:0]   cnum_in [3];
   logic [2:0]        neg4_ff, neg4_in, neg5_ff;
   logic [PC_W-1:0]   cprod_ff [3];
   logic [CHAN_W-1:0] chan [3];
   logic [COLOR_W-1:0] color_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= START_RESET;
            end_ff[i]   <= END_RESET;
         end
         dir_ff <= DIR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_RED:   start_ff[0] <= csr_wdata;
            REG_START_GREEN: start_ff[1] <= csr_wdata;
            REG_START_BLUE:  start_ff[2] <= csr_wdata;
            REG_END_RED:     end_ff[0]   <= csr_wdata;
            REG_END_GREEN:   end_ff[1]   <= csr_wdata;
            REG_END_BLUE:    end_ff[2]   <= csr_wdata;
            REG_DIRECTION:   dir_ff      <= direction_type'(csr_wdata[1:0]);
            default: begin
            end
         endcase
      end
   end

   // Each numerator is 2*a*b + c, so that a reciprocal multiply gives the rounded quotient.
   always_comb begin
      if (dir_ff == DIR_VERTICAL) begin
         ynum_in = NY_W'(2 * PALETTE_SIZE * int'(req_pixel_y) + IMAGE_HEIGHT);
      end else begin
         ynum_in = NY_W'(2 * HALF * int'(req_pixel_y) + IMAGE_HEIGHT);
      end
      if (dir_ff == DIR_HORIZONTAL) begin
         xnum_in = NX_W'(2 * PALETTE_SIZE * int'(req_pixel_x) + IMAGE_WIDTH);
      end else begin
         xnum_in = NX_W'(2 * (HALF - 1) * int'(req_pixel_x) + IMAGE_WIDTH);
      end
   end

   // The mirrored case subtracts the horizontal term from the far end of the row.
   always_comb begin
      case (dir_ff)
         DIR_VERTICAL:   sum = CB_W'(yprod_ff[SY +: NY_W]);
         DIR_HORIZONTAL: sum = CB_W'(xprod_ff[SX +: NX_W]);
         DIR_DIAGONAL:   sum = CB_W'(yprod_ff[SY +: NY_W]) + CB_W'(xprod_ff[SX +: NX_W]);
         DIR_MIRRORED:   sum = CB_W'(yprod_ff[SY +: NY_W]) + CB_W'(HALF - 1)
                               - CB_W'(xprod_ff[SX +: NX_W]);
         default:        sum = '0;
      endcase
      if (sum[CB_W-1]) begin
         idx_in = '0;
      end else if (sum > CB_W'(PALETTE_SIZE - 1)) begin
         idx_in = IDX_W'(PALETTE_SIZE - 1);
      end else begin
         idx_in = sum[IDX_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg4_in[i] = end_ff[i] < start_ff[i];
         if (neg4_in[i]) begin
            cnum_in[i] = NC_W'(2 * int'(start_ff[i] - end_ff[i]) * int'(idx_ff)
                               + PALETTE_SIZE - 1);
         end else begin
            cnum_in[i] = NC_W'(2 * int'(end_ff[i] - start_ff[i]) * int'(idx_ff)
                               + PALETTE_SIZE - 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (neg5_ff[i]) begin
            chan[i] = start_ff[i] - cprod_ff[i][SC +: CHAN_W];
         end else begin
            chan[i] = start_ff[i] + cprod_ff[i][SC +: CHAN_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         rsp_strobe_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      ynum_ff  <= ynum_in;
      xnum_ff  <= xnum_in;
      yprod_ff <= PY_W'(ynum_ff) * PY_W'(MY);
      xprod_ff <= PX_W'(xnum_ff) * PX_W'(MX);
      idx_ff   <= idx_in;
      neg4_ff  <= neg4_in;
      neg5_ff  <= neg4_ff;
      for (int i = 0; i < 3; i++) begin
         cnum_ff[i]  <= cnum_in[i];
         cprod_ff[i] <= PC_W'(cnum_ff[i]) * PC_W'(MC);
      end
      color_ff <= {chan[0], chan[1], chan[2]};
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_color = color_ff;

   `ASSERT_IMPL(a_strobe_from_request, clock, reset, rsp_strobe, $past(accept, LAT))
   `ASSERT_IMPL(a_index_in_palette, clock, reset, v3_ff, idx_ff <= IDX_W'(PALETTE_SIZE - 1))
   `ASSERT_NEXT(a_reset_clears_strobe, clock, 1'b0, reset, !rsp_strobe)

endmodule

### test/tb.sv
module tb;
   import pgpg_pkg::*;

   localparam int PIPE_LATENCY = 6;
   localparam int RANDOM_PHASES = 8;
   localparam int PIXELS_PER_PHASE = 212;
   localparam longint RUN_LIMIT = 64'd1_000_000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam longint PAL_N = PGPG_PALETTE_SIZE;
   localparam longint PAL_HALF = PGPG_PALETTE_SIZE / 2;
   localparam longint IMG_W = PGPG_IMAGE_WIDTH;
   localparam longint IMG_H = PGPG_IMAGE_HEIGHT;

   typedef struct {
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      logic [COLOR_W-1:0] color;
   } color_entry_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [X_W-1:0]        req_pixel_x;
   logic [Y_W-1:0]        req_pixel_y;
   logic                  rsp_strobe;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [CHAN_W-1:0] grad_start [3];
   logic [CHAN_W-1:0] grad_end [3];
   direction_type     grad_dir;

   color_entry_type pending_colors [$];
   int pixels_sent = 0;
   int colors_checked = 0;
   int error_count = 0;
   int palette_settings = 1;
   int burst_left = 1;

   palette_gradient_pixel_generator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_color (rsp_pixel_color),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT * 4);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint scaled_round(longint a, longint b, longint c);
      longint p;
      longint mag;
      longint q;
      p = a * b;
      mag = (p < 0) ? -p : p;
      q = (2 * mag + c) / (2 * c);
      return (p < 0) ? -q : q;
   endfunction

   function automatic longint palette_index(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      longint px;
      longint py;
      longint idx;
      px = longint'(x);
      py = longint'(y);
      case (grad_dir)
         DIR_VERTICAL: idx = scaled_round(PAL_N, py, IMG_H);
         DIR_HORIZONTAL: idx = scaled_round(PAL_N, px, IMG_W);
         DIR_DIAGONAL: idx = scaled_round(PAL_HALF, py, IMG_H)
                             + scaled_round(PAL_HALF - 1, px, IMG_W);
         default: idx = scaled_round(PAL_HALF, py, IMG_H) + PAL_HALF - 1
                        + scaled_round(1 - PAL_HALF, px, IMG_W);
      endcase
      if (idx < 0) idx = 0;
      if (idx > PAL_N - 1) idx = PAL_N - 1;
      return idx;
   endfunction

   function automatic logic [COLOR_W-1:0] gradient_color(logic [X_W-1:0] x,
                                                         logic [Y_W-1:0] y);
      longint idx;
      longint level;
      logic [COLOR_W-1:0] color;
      idx = palette_index(x, y);
      for (int c = 0; c < 3; c++) begin
         level = longint'(grad_start[c])
                 + scaled_round(longint'(grad_end[c]) - longint'(grad_start[c]),
                                idx, PAL_N - 1);
         color[(2 - c) * CHAN_W +: CHAN_W] = level[CHAN_W-1:0];
      end
      return color;
   endfunction

   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      color_entry_type want;
      string chan_name [3];
      chan_name = '{"red", "green", "blue"};
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            report_error("result strobe is unknown");
         end else if (pending_colors.size() == 0) begin
            report_error($sformatf("color %06h with no pixel outstanding",
                                   rsp_pixel_color));
         end else begin
            want = pending_colors.pop_front();
            colors_checked++;
            for (int c = 0; c < 3; c++) begin
               if (rsp_pixel_color[(2 - c) * CHAN_W +: CHAN_W]
                   !== want.color[(2 - c) * CHAN_W +: CHAN_W])
                  report_error($sformatf("pixel (%0d,%0d) %s got %02h expected %02h",
                     want.x, want.y, chan_name[c],
                     rsp_pixel_color[(2 - c) * CHAN_W +: CHAN_W],
                     want.color[(2 - c) * CHAN_W +: CHAN_W]));
            end
         end
      end
   end

   task automatic send_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      color_entry_type entry;
      start <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (busy !== 1'b0);
      entry.x = x;
      entry.y = y;
      entry.color = gradient_color(x, y);
      pending_colors.push_back(entry);
      pixels_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic drain_pixels;
      start <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_START_RED:   grad_start[0] = data;
         REG_START_GREEN: grad_start[1] = data;
         REG_START_BLUE:  grad_start[2] = data;
         REG_END_RED:     grad_end[0] = data;
         REG_END_GREEN:   grad_end[1] = data;
         REG_END_BLUE:    grad_end[2] = data;
         REG_DIRECTION:   grad_dir = direction_type'(data[1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CHAN_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_reset_defaults;
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd319, 8'd239);
      send_pixel(9'd511, 8'd0);
      send_pixel(9'd0, 8'd255);
   endtask

   task automatic test_directions;
      for (int d = 0; d < 4; d++) begin
         drain_pixels();
         palette_settings++;
         csr_write(REG_DIRECTION, 8'hFC | CSR_DATA_W'(d));
         send_pixel(9'd0, 8'd0);
         send_pixel(9'd319, 8'd239);
         send_pixel(9'd511, 8'd255);
      end
   endtask

   task automatic test_register_writes;
      drain_pixels();
      palette_settings++;
      csr_write(REG_START_RED, 8'hFF);
      csr_write(REG_START_GREEN, 8'hFF);
      csr_write(REG_START_BLUE, 8'hFF);
      csr_write(REG_END_RED, 8'h00);
      csr_write(REG_END_GREEN, 8'h00);
      csr_write(REG_END_BLUE, 8'h00);
      csr_write(REG_UNUSED, 8'h5A);
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd160, 8'd120);
      send_pixel(9'd319, 8'd239);
      drain_pixels();
      palette_settings++;
      csr_write(REG_START_RED, 8'h80);
      csr_write(REG_END_RED, 8'h80);
      send_pixel(9'd100, 8'd100);
   endtask

   task automatic test_random_gradients;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pixels();
         palette_settings++;
         csr_write(REG_START_RED, pick_level());
         csr_write(REG_START_GREEN, pick_level());
         csr_write(REG_START_BLUE, pick_level());
         csr_write(REG_END_RED, pick_level());
         csr_write(REG_END_GREEN, pick_level());
         csr_write(REG_END_BLUE, pick_level());
         csr_write(REG_DIRECTION, {6'($urandom_range(0, 63)), 2'(phase)});
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            x = ($urandom_range(0, 9) == 0) ? X_W'($urandom_range(0, 511))
                                            : X_W'($urandom_range(0, 319));
            y = ($urandom_range(0, 9) == 0) ? Y_W'($urandom_range(0, 255))
                                            : Y_W'($urandom_range(0, 239));
            send_pixel(x, y);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      grad_start = '{START_RESET, START_RESET, START_RESET};
      grad_end = '{END_RESET, END_RESET, END_RESET};
      grad_dir = DIR_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_directions();
      test_register_writes();
      test_random_gradients();

      drain_pixels();
      repeat (2 * PIPE_LATENCY) @(negedge clock);
      if (pending_colors.size() != 0)
         report_error($sformatf("%0d colors never arrived", pending_colors.size()));

      $display("Sent %0d pixels under %0d palette settings, all four directions,",
               pixels_sent, palette_settings);
      $display("coordinates beyond the image included; %0d colors compared, %0d errors.",
               colors_checked, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### palette_gradient_pixel_generator.f
+incdir+hw/rtl
hw/rtl/pgpg_pkg.sv
hw/rtl/palette_gradient_pixel_generator.sv
test/tb.sv
